### hdl/ole_pkg.sv
// Shared types and codes for the ordered list engine.
package ole_pkg;

    typedef enum logic [3:0] {
        OP_INS_FIRST      = 4'd0,
        OP_INS_LAST       = 4'd1,
        OP_INS_AFTER_KEY  = 4'd2,
        OP_INS_BEFORE_KEY = 4'd3,
        OP_INS_AFTER_POS  = 4'd4,
        OP_INS_BEFORE_POS = 4'd5,
        OP_DEL_KEY        = 4'd6,
        OP_DEL_AFTER_KEY  = 4'd7,
        OP_SEARCH         = 4'd8,
        OP_NEXT_OF        = 4'd9,
        OP_PREV_OF        = 4'd10,
        OP_DUMP           = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NO_NEIGH  = 3'd4
    } status_t;

    localparam int MAX_RESULTS = 16;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write_new;
    } ctrl_t;

endpackage

### hdl/ole_store.sv
// Element store with a single shared key compare and shift network.
module ole_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 4
) (
    input  logic                  aclk,
    input  ole_pkg::ctrl_t        ctrl,
    input  logic [IW-1:0]         idx,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] wr_value,
    output logic                  hit,
    output logic [DATA_WIDTH-1:0] rd_value
);
    logic [DATA_WIDTH-1:0] entries_reg [CAPACITY];

    // One slot per cycle: shift up copies idx-1 into idx, shift down idx+1 into idx.
    always_ff @(posedge aclk) begin
        if (ctrl.write_new) begin
            entries_reg[idx] <= wr_value;
        end else if (ctrl.shift_up) begin
            entries_reg[idx] <= entries_reg[idx - IW'(1)];
        end else if (ctrl.shift_down) begin
            entries_reg[idx] <= entries_reg[idx + IW'(1)];
        end
    end

    assign rd_value = entries_reg[idx];
    assign hit      = (entries_reg[idx] == key);
endmodule

### hdl/ordered_list_engine_core.sv
// Top level of the ordered list engine: sequencer, store and result register.
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | tdata: operation, search_key, new_value, position
//  m_      | out | m_tvalid / m_tready   | tdata: status, result_value, result_position,
//          |     |                       |        element_count; tlast: last_result
//
// One request walks the store one slot a cycle through the shared compare or shift
// unit: a key scan, then a shift or neighbour read, plus the decode, resolve and
// output states and the idle state that accepts the beat; a dump sends one element
// per beat, each waiting on m_tready.
// Reset clears count and the sequencer; slot contents are left as they are.
// s_tready is high only in the idle state once the previous result beat is taken.
module ordered_list_engine_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] operation, [35:4] search_key, [67:36] new_value, [72:68] position
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [34:3] result_value, [39:35] result_position, [44:40] element_count
    output logic [47:0]  m_tdata,
    output logic         m_tlast
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_RESV  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_DUMP  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]            op_reg;
    logic [DATA_WIDTH-1:0] key_reg, nv_reg;
    logic [4:0]            pos_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW:0]           scan_reg, scan_next;   // scan index, can reach count
    logic [CW:0]           match_reg, match_next; // match index, valid if found_reg
    logic                  found_reg, found_next;
    logic [CW:0]           ins_reg, ins_next;     // target slot
    logic                  ins_mode_reg, ins_mode_next; // 1 insert, 0 delete
    logic [CW:0]           ptr_reg, ptr_next;
    logic [2:0]            st_reg, st_next;
    logic [31:0]           rval_reg, rval_next;
    logic [4:0]            rpos_reg, rpos_next;
    logic                  last_reg, last_next;
    logic                  mv_reg, mv_next;

    ole_pkg::ctrl_t        ctrl;
    logic [IW-1:0]         idx;
    logic                  hit;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [DATA_WIDTH-1:0] in_key, in_nv;
    logic [CW:0]           count_x;
    logic [4:0]            dump_n;

    assign in_key  = DATA_WIDTH'($signed(s_tdata[35:4]));
    assign in_nv   = DATA_WIDTH'($signed(s_tdata[67:36]));
    assign count_x = {1'b0, count_reg};
    assign dump_n  = (count_x > (CW+1)'(ole_pkg::MAX_RESULTS)) ?
                     5'(ole_pkg::MAX_RESULTS) : 5'(count_x);

    function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] v);
        return 32'($signed(v));
    endfunction

    ole_store #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH), .IW(IW)) u_store (
        .aclk(aclk), .ctrl(ctrl), .idx(idx), .key(key_reg), .wr_value(nv_reg),
        .hit(hit), .rd_value(rd_value)
    );

    // Hold off a new request until the waiting result beat leaves.
    assign s_tready = (state_reg == S_IDLE) && (!mv_reg || m_tready);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'd0, 5'(count_x), rpos_reg, rval_reg, st_reg};
    assign m_tlast  = last_reg;

    always_comb begin
        state_next = state_reg;   count_next = count_reg;
        scan_next = scan_reg;     match_next = match_reg;  found_next = found_reg;
        ins_next = ins_reg;       ins_mode_next = ins_mode_reg;
        ptr_next = ptr_reg;       st_next = st_reg;        rval_next = rval_reg;
        rpos_next = rpos_reg;     last_next = last_reg;    mv_next = mv_reg;
        ctrl = '0;
        idx = IW'(scan_reg);

        if (mv_reg && m_tready) mv_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = S_DEC;
                    scan_next = '0; found_next = 1'b0; ptr_next = '0;
                end
            end
            S_DEC: begin
                st_next = ole_pkg::ST_OK; rval_next = '0; rpos_next = '0;
                last_next = 1'b1; ins_mode_next = 1'b1;
                unique case (op_reg)
                    ole_pkg::OP_INS_FIRST: begin
                        ins_next = '0; state_next = S_RESV;
                    end
                    ole_pkg::OP_INS_LAST: begin
                        ins_next = count_x; state_next = S_RESV;
                    end
                    ole_pkg::OP_INS_AFTER_POS: begin
                        if ({1'b0, pos_reg} > 6'(count_x)) begin
                            st_next = ole_pkg::ST_BAD_POS; state_next = S_OUT;
                        end else begin
                            ins_next = (CW+1)'(pos_reg); state_next = S_RESV;
                        end
                    end
                    ole_pkg::OP_INS_BEFORE_POS: begin
                        if (pos_reg == 5'd0 || {1'b0, pos_reg} > 6'(count_x) + 6'd1) begin
                            st_next = ole_pkg::ST_BAD_POS; state_next = S_OUT;
                        end else begin
                            ins_next = (CW+1)'(pos_reg - 5'd1); state_next = S_RESV;
                        end
                    end
                    ole_pkg::OP_DUMP: begin
                        if (count_reg == '0) state_next = S_OUT;
                        else begin
                            ptr_next = '0; state_next = S_DUMP;
                        end
                    end
                    ole_pkg::OP_INS_AFTER_KEY, ole_pkg::OP_INS_BEFORE_KEY,
                    ole_pkg::OP_DEL_KEY, ole_pkg::OP_DEL_AFTER_KEY,
                    ole_pkg::OP_SEARCH, ole_pkg::OP_NEXT_OF,
                    ole_pkg::OP_PREV_OF: state_next = S_SCAN;
                    default: state_next = S_OUT;
                endcase
            end
            S_SCAN: begin
                // compare one slot per cycle; stop on first hit or at count
                if (scan_reg < count_x && hit) begin
                    found_next = 1'b1; match_next = scan_reg; state_next = S_RESV;
                end else if (scan_reg >= count_x) begin
                    state_next = S_RESV;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_RESV: begin
                state_next = S_OUT;
                if ((op_reg == ole_pkg::OP_INS_AFTER_KEY ||
                     op_reg == ole_pkg::OP_INS_BEFORE_KEY ||
                     op_reg == ole_pkg::OP_DEL_KEY || op_reg == ole_pkg::OP_DEL_AFTER_KEY ||
                     op_reg == ole_pkg::OP_SEARCH || op_reg == ole_pkg::OP_NEXT_OF ||
                     op_reg == ole_pkg::OP_PREV_OF) && !found_reg) begin
                    st_next = ole_pkg::ST_NOT_FOUND;
                end else begin
                    unique case (op_reg)
                        ole_pkg::OP_INS_AFTER_KEY, ole_pkg::OP_INS_BEFORE_KEY,
                        ole_pkg::OP_INS_FIRST, ole_pkg::OP_INS_LAST,
                        ole_pkg::OP_INS_AFTER_POS, ole_pkg::OP_INS_BEFORE_POS: begin
                            if (op_reg == ole_pkg::OP_INS_AFTER_KEY)
                                ins_next = match_reg + 1'b1;
                            else if (op_reg == ole_pkg::OP_INS_BEFORE_KEY)
                                ins_next = match_reg;
                            if (count_x >= (CW+1)'(CAPACITY)) begin
                                st_next = ole_pkg::ST_FULL;
                            end else begin
                                ptr_next = count_x; ins_mode_next = 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        ole_pkg::OP_DEL_KEY: begin
                            ptr_next = match_reg; ins_mode_next = 1'b0;
                            state_next = S_SHIFT;
                        end
                        ole_pkg::OP_DEL_AFTER_KEY: begin
                            if (match_reg + 1'b1 >= count_x) st_next = ole_pkg::ST_NO_NEIGH;
                            else begin
                                ptr_next = match_reg + 1'b1; ins_mode_next = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        ole_pkg::OP_SEARCH: rpos_next = 5'(match_reg + 1'b1);
                        ole_pkg::OP_NEXT_OF: begin
                            if (match_reg + 1'b1 >= count_x) st_next = ole_pkg::ST_NO_NEIGH;
                            else begin
                                ptr_next = match_reg + 1'b1; state_next = S_SHIFT;
                                ins_mode_next = 1'b0;
                            end
                        end
                        ole_pkg::OP_PREV_OF: begin
                            if (match_reg == '0) st_next = ole_pkg::ST_NO_NEIGH;
                            else begin
                                ptr_next = match_reg - 1'b1; state_next = S_SHIFT;
                                ins_mode_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                idx = IW'(ptr_reg);
                if (op_reg == ole_pkg::OP_NEXT_OF || op_reg == ole_pkg::OP_PREV_OF) begin
                    // neighbour read only
                    rval_next = to_out(rd_value); state_next = S_OUT;
                end else if (ins_mode_reg) begin
                    if (ptr_reg == ins_reg) begin
                        ctrl.write_new = 1'b1; count_next = count_reg + 1'b1;
                        state_next = S_OUT;
                    end else begin
                        ctrl.shift_up = 1'b1; ptr_next = ptr_reg - 1'b1;
                    end
                end else begin
                    if (ptr_reg + 1'b1 >= count_x) begin
                        count_next = count_reg - 1'b1; state_next = S_OUT;
                    end else begin
                        ctrl.shift_down = 1'b1; ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            S_DUMP: begin
                idx = IW'(ptr_reg);
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1; st_next = ole_pkg::ST_OK;
                    rval_next = to_out(rd_value);
                    rpos_next = 5'(ptr_reg + 1'b1);
                    last_next = (5'(ptr_reg + 1'b1) == dump_n);
                    ptr_next = ptr_reg + 1'b1;
                    if (5'(ptr_reg + 1'b1) == dump_n) state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tdata[3:0];
            key_reg <= in_key;
            nv_reg  <= in_nv;
            pos_reg <= s_tdata[72:68];
        end
        scan_reg <= scan_next;       match_reg <= match_next;  found_reg <= found_next;
        ins_reg <= ins_next;         ins_mode_reg <= ins_mode_next;
        ptr_reg <= ptr_next;         st_reg <= st_next;        rval_reg <= rval_next;
        rpos_reg <= rpos_next;       last_reg <= last_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_x <= (CW+1)'(CAPACITY))
        else $error("count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(ctrl.shift_up || ctrl.shift_down || ctrl.write_new))
        else $error("store written while idle");
endmodule
